FILE: design/barometer_integer_compensation_defines.svh
// assertion macros for the barometer compensation block
`ifndef BAROMETER_INTEGER_COMPENSATION_DEFINES_SVH
`define BAROMETER_INTEGER_COMPENSATION_DEFINES_SVH
// assert that a condition implies a consequence in the same cycle
`define BIC_ASSERT_IMPL(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error(msg);
// assert that a condition implies a consequence in the next cycle
`define BIC_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error(msg);
`endif

FILE: design/bic_pkg.sv
// ----------------------------------------------------------------------------
// bic_pkg
// types and constants shared by the barometer compensation block
// ----------------------------------------------------------------------------
package bic_pkg;
	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_RAW_ZERO = 3'd1,
		ST_DEN_ZERO = 3'd2,
		ST_B4_ZERO  = 3'd3,
		ST_P_NONPOS = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		REG_GROUP_A = 2'd0,
		REG_GROUP_B = 2'd1,
		REG_GROUP_C = 2'd2,
		REG_OSS     = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [63:0] grp_a;
		logic [63:0] grp_b;
		logic [31:0] grp_c;
		logic [1:0]  oss;
	} cfg_t;

	// arithmetic right shift of a 32-bit word
	function automatic logic [31:0] asr(input logic [31:0] v, input int unsigned n);
		asr = 32'($signed(v) >>> n);
	endfunction

	function automatic logic [31:0] sx16(input logic [15:0] v);
		sx16 = {{16{v[15]}}, v};
	endfunction
endpackage

FILE: design/bic_stream_if.sv
// ----------------------------------------------------------------------------
// bic_stream_if
// valid/ready channel with a generic payload
// ----------------------------------------------------------------------------
interface bic_stream_if #(parameter int unsigned W = 8);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: design/bic_div.sv
// ----------------------------------------------------------------------------
// bic_div
// pipelined unsigned 32-bit restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module bic_div
	import bic_pkg::*;
#(
	parameter int unsigned SW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [31:0]   dividend,
	input  logic [31:0]   divisor,
	input  logic [SW-1:0] side_in,
	output logic          out_valid,
	output logic [31:0]   quotient,
	output logic [SW-1:0] side_out
);
	logic [32:0]   rem_s [0:32];
	logic [31:0]   num_s [0:32];
	logic [31:0]   den_s [0:32];
	logic [SW-1:0] side_s [0:32];
	logic          vld_s [0:32];

	assign rem_s[0]  = '0;
	assign num_s[0]  = dividend;
	assign den_s[0]  = divisor;
	assign side_s[0] = side_in;
	assign vld_s[0]  = in_valid;

	// one shift-subtract step per stage
	for (genvar i = 0; i < 32; i++) begin : g_step
		logic [32:0] sh;
		logic [32:0] diff;
		assign sh   = {rem_s[i][31:0], num_s[i][31]};
		assign diff = sh - {1'b0, den_s[i]};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (!diff[32]) begin
					rem_s[i+1] <= diff;
					num_s[i+1] <= {num_s[i][30:0], 1'b1};
				end else begin
					rem_s[i+1] <= sh;
					num_s[i+1] <= {num_s[i][30:0], 1'b0};
				end
				den_s[i+1]  <= den_s[i];
				side_s[i+1] <= side_s[i];
			end
		end
	end

	assign out_valid = vld_s[32];
	assign quotient  = num_s[32];
	assign side_out  = side_s[32];
endmodule

FILE: design/bic_temp.sv
// ----------------------------------------------------------------------------
// bic_temp
// temperature front end: x1, denominator, signed division, b5
// ----------------------------------------------------------------------------
module bic_temp
	import bic_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  logic [15:0] ut,
	input  logic [18:0] up,
	input  cfg_t        cfg,
	output logic        out_valid,
	output logic [31:0] b5,
	output logic [18:0] up_o,
	output status_t     st_o
);
	typedef struct packed {
		logic [31:0] x1;
		logic [18:0] up;
		logic        neg;
		status_t     st;
	} side_t;

	logic        v_s1;
	logic [31:0] prod_s1, md_s1, mc_s1;
	logic [18:0] up_s1;
	logic        raw0_s1;
	logic        v_s2;
	logic [31:0] x1_s2, den_s2, num_s2;
	logic [18:0] up_s2;
	status_t     st_s2;
	logic [31:0] ma, mb, q;
	logic        dv;
	side_t       sin, sout;

	// stage 1: (ut - ac6) * ac5
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= ({16'd0, ut} - {16'd0, cfg.grp_b[31:16]}) * {16'd0, cfg.grp_b[15:0]};
			md_s1   <= sx16(cfg.grp_c[31:16]);
			mc_s1   <= sx16(cfg.grp_c[15:0]) << 11;
			up_s1   <= up;
			raw0_s1 <= (ut == '0) || (up == '0);
		end
	end

	// stage 2: x1 and denominator
	always_ff @(posedge clk) begin
		if (en) begin
			x1_s2  <= asr(prod_s1, 15);
			den_s2 <= asr(prod_s1, 15) + md_s1;
			num_s2 <= mc_s1;
			up_s2  <= up_s1;
			if (raw0_s1) st_s2 <= ST_RAW_ZERO;
			else if ((asr(prod_s1, 15) + md_s1) == '0) st_s2 <= ST_DEN_ZERO;
			else st_s2 <= ST_OK;
		end
	end

	// magnitudes into the divider
	always_comb begin
		ma = num_s2[31] ? (32'd0 - num_s2) : num_s2;
		mb = den_s2[31] ? (32'd0 - den_s2) : den_s2;
		if (mb == '0) mb = 32'd1;
		sin = '{x1: x1_s2, up: up_s2, neg: num_s2[31] ^ den_s2[31], st: st_s2};
	end

	bic_div #(.SW($bits(side_t))) u_div (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s2),
		.dividend(ma), .divisor(mb), .side_in(sin),
		.out_valid(dv), .quotient(q), .side_out(sout)
	);

	// stage after division: b5
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= dv;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			b5   <= sout.x1 + (sout.neg ? (32'd0 - q) : q);
			up_o <= sout.up;
			st_o <= sout.st;
		end
	end
endmodule

FILE: design/bic_press.sv
// ----------------------------------------------------------------------------
// bic_press
// pressure path: b6 products, b3, b4, b7, division and final correction
// ----------------------------------------------------------------------------
module bic_press
	import bic_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  logic [31:0] b5,
	input  logic [18:0] up,
	input  status_t     st,
	input  cfg_t        cfg,
	output logic        out_valid,
	output logic [15:0] temperature_tenths,
	output logic [19:0] pressure_pa,
	output status_t     status
);
	typedef struct packed {
		logic [15:0] t;
		logic        halve;
		status_t     st;
	} side_t;

	logic [31:0] b5p8, t32;
	logic [15:0] tsat;
	// stage a
	logic        v_a;
	logic [31:0] b6_a;
	logic [15:0] t_a;
	logic [18:0] up_a;
	status_t     st_a;
	// stage b
	logic        v_b;
	logic [31:0] sq_b, ac2b6_b, ac3b6_b, b6_b;
	logic [15:0] t_b;
	logic [18:0] up_b;
	status_t     st_b;
	// stage c
	logic        v_c;
	logic [31:0] b2sq_c, b1sq_c, ac2b6_c, ac3b6_c;
	logic [15:0] t_c;
	logic [18:0] up_c;
	status_t     st_c;
	// stage d
	logic        v_d;
	logic [31:0] b3_d, x3_d;
	logic [15:0] t_d;
	logic [18:0] up_d;
	status_t     st_d;
	// stage e
	logic        v_e;
	logic [31:0] b4_e, b7_e;
	logic [15:0] t_e;
	status_t     st_e;
	logic [31:0] b4c, dnd, dsr;
	logic [31:0] q;
	logic        dv;
	side_t       sin, sout;
	// post division
	logic        v_f;
	logic [31:0] p_f;
	logic [15:0] t_f;
	status_t     st_f;
	logic        v_g;
	logic [31:0] p_g, sq_g, x2_g;
	logic [15:0] t_g;
	status_t     st_g;
	logic        v_h;
	logic [31:0] p_h, x1_h, x2_h;
	logic [15:0] t_h;
	status_t     st_h;
	logic [31:0] pfin;

	// temperature from b5, saturated to 16 bits
	always_comb begin
		b5p8 = b5 + 32'd8;
		t32  = asr(b5p8, 4);
		if ($signed(t32) > 32'sd32767) tsat = 16'h7FFF;
		else if ($signed(t32) < -32'sd32768) tsat = 16'h8000;
		else tsat = t32[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_a <= 1'b0; v_b <= 1'b0; v_c <= 1'b0; v_d <= 1'b0; v_e <= 1'b0;
			v_f <= 1'b0; v_g <= 1'b0; v_h <= 1'b0; out_valid <= 1'b0;
		end else if (en) begin
			v_a <= in_valid; v_b <= v_a; v_c <= v_b; v_d <= v_c; v_e <= v_d;
			v_f <= dv; v_g <= v_f; v_h <= v_g; out_valid <= v_h;
		end
	end

	// stages a through e ahead of the divider
	always_ff @(posedge clk) begin
		if (en) begin
			b6_a <= b5 - 32'd4000;
			t_a  <= (st == ST_OK) ? tsat : 16'd0;
			up_a <= up;
			st_a <= st;

			sq_b    <= asr(b6_a * b6_a, 12);
			ac2b6_b <= sx16(cfg.grp_a[31:16]) * b6_a;
			ac3b6_b <= sx16(cfg.grp_a[47:32]) * b6_a;
			b6_b    <= b6_a;
			t_b     <= t_a;
			up_b    <= up_a;
			st_b    <= st_a;

			b2sq_c  <= sx16(cfg.grp_b[63:48]) * sq_b;
			b1sq_c  <= sx16(cfg.grp_b[47:32]) * sq_b;
			ac2b6_c <= ac2b6_b;
			ac3b6_c <= ac3b6_b;
			t_c     <= t_b;
			up_c    <= up_b;
			st_c    <= st_b;

			b3_d <= asr(((sx16(cfg.grp_a[15:0]) * 32'd4 + asr(b2sq_c, 11)
				+ asr(ac2b6_c, 11)) << cfg.oss) + 32'd2, 2);
			x3_d <= asr(asr(ac3b6_c, 13) + asr(b1sq_c, 16) + 32'd2, 2);
			t_d  <= t_c;
			up_d <= up_c;
			st_d <= st_c;

			b4_e <= ({16'd0, cfg.grp_a[63:48]} * (x3_d + 32'd32768)) >> 15;
			b7_e <= ({13'd0, up_d} - b3_d) * (32'd50000 >> cfg.oss);
			t_e  <= t_d;
			st_e <= st_d;
		end
	end

	// divider inputs and status for b4
	always_comb begin
		b4c = (b4_e == '0) ? 32'd1 : b4_e;
		dnd = b7_e[31] ? b7_e : (b7_e << 1);
		dsr = b4c;
		sin.t     = t_e;
		sin.halve = b7_e[31];
		sin.st    = (st_e == ST_OK && b4_e == '0) ? ST_B4_ZERO : st_e;
	end

	bic_div #(.SW($bits(side_t))) u_div (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_e),
		.dividend(dnd), .divisor(dsr), .side_in(sin),
		.out_valid(dv), .quotient(q), .side_out(sout)
	);

	// correction stages
	always_ff @(posedge clk) begin
		if (en) begin
			p_f  <= sout.halve ? (q << 1) : q;
			t_f  <= sout.t;
			st_f <= sout.st;

			sq_g <= asr(p_f, 8) * asr(p_f, 8);
			x2_g <= (32'd0 - 32'd7357) * p_f;
			p_g  <= p_f;
			t_g  <= t_f;
			st_g <= st_f;

			x1_h <= asr(sq_g * 32'd3038, 16);
			x2_h <= asr(x2_g, 16);
			p_h  <= p_g;
			t_h  <= t_g;
			st_h <= st_g;
		end
	end

	assign pfin = p_h + asr(x1_h + x2_h + 32'd3791, 4);

	// output register
	always_ff @(posedge clk) begin
		if (en) begin
			temperature_tenths <= t_h;
			if (st_h != ST_OK) begin
				status      <= st_h;
				pressure_pa <= '0;
			end else if ($signed(pfin) <= 32'sd0) begin
				status      <= ST_P_NONPOS;
				pressure_pa <= '0;
			end else begin
				status      <= ST_OK;
				pressure_pa <= ($signed(pfin) > 32'sd1048575) ? 20'hFFFFF : pfin[19:0];
			end
		end
	end
endmodule

FILE: design/barometer_integer_compensation.sv
// throughput: one beat per cycle while the output is not stalled, set
// by the two 32-stage pipelined dividers
// a stall on the output holds the whole pipeline; no beat is lost or repeated
// reset clears the valid bits and all configuration registers to zero
// ----------------------------------------------------------------------------
// barometer_integer_compensation
// pipelined integer temperature and pressure compensation
// ----------------------------------------------------------------------------
module barometer_integer_compensation
	import bic_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	bic_stream_if.sink   cfg_wr,
	bic_stream_if.sink   samples,
	bic_stream_if.source results
);
	cfg_t        cfg_q;
	logic        en;
	logic        tv;
	logic [31:0] b5;
	logic [18:0] up;
	status_t     st;
	logic        pv;
	logic [15:0] t_o;
	logic [19:0] p_o;
	status_t     s_o;
	logic [1:0]  widx;
	logic [63:0] wdat;

	// cfg_wr.data: value in bits 63:0, register index in bits 71:64
	assign widx = cfg_wr.data[65:64];
	assign wdat = cfg_wr.data[63:0];
	assign cfg_wr.ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr.valid && cfg_wr.data[71:66] == '0) begin
			unique case (reg_idx_t'(widx))
				REG_GROUP_A: cfg_q.grp_a <= wdat;
				REG_GROUP_B: cfg_q.grp_b <= wdat;
				REG_GROUP_C: cfg_q.grp_c <= wdat[31:0];
				REG_OSS:     cfg_q.oss   <= wdat[1:0];
				default:     cfg_q <= cfg_q;
			endcase
		end
	end

	// the pipeline advances unless a result is held at the output
	assign en = !results.valid || results.ready;
	assign samples.ready = en;

	bic_temp u_temp (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(samples.valid),
		.ut(samples.data[15:0]), .up(samples.data[34:16]), .cfg(cfg_q),
		.out_valid(tv), .b5(b5), .up_o(up), .st_o(st)
	);

	bic_press u_press (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(tv), .b5(b5), .up(up),
		.st(st), .cfg(cfg_q), .out_valid(pv), .temperature_tenths(t_o),
		.pressure_pa(p_o), .status(s_o)
	);

	assign results.valid = pv;
	assign results.data  = {s_o, p_o, t_o};
endmodule

FILE: design/bic_checker.sv
// ----------------------------------------------------------------------------
// bic_checker
// port-level checks on the result channel
// ----------------------------------------------------------------------------
`include "barometer_integer_compensation_defines.svh"
module bic_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_ready,
	input logic        r_valid,
	input logic        r_ready,
	input logic [38:0] r_data
);
	// stalled result holds
	`BIC_ASSERT_NEXT(a_hold, clk, arst_n, r_valid && !r_ready, r_valid && $stable(r_data), "result changed under stall")
	// failed status carries zero pressure
	`BIC_ASSERT_IMPL(a_zero_p, clk, arst_n, r_valid && r_data[38:36] != 3'd0, r_data[35:16] == '0, "pressure nonzero on error")
	// status code in range
	`BIC_ASSERT_IMPL(a_code, clk, arst_n, r_valid, r_data[38:36] <= 3'd4, "bad status")
	// input is stalled while a result is held
	`BIC_ASSERT_IMPL(a_bp, clk, arst_n, r_valid && !r_ready, !s_ready, "input taken during stall")
endmodule

bind barometer_integer_compensation bic_checker u_bic_checker (
	.clk(clk), .arst_n(arst_n), .s_ready(samples.ready), .r_valid(results.valid),
	.r_ready(results.ready), .r_data(results.data)
);

FILE: tb/barometer_integer_compensation_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barometer_integer_compensation_test
// Self-checking bench for the pipelined barometer compensation block.
// A directed table walks reset values, a typical calibration and each error
// status. Random phases follow, each with its own calibration, over three idling mixes.
// Every result beat is checked against a table value or an in-bench model of the integer math.
// ----------------------------------------------------------------------------
module barometer_integer_compensation_test
	import bic_pkg::*;
();
	localparam int CfgW = 72;
	localparam int SmpW = 35;
	localparam int ResW = 39;
	localparam int WatchdogLimit = 20000;
	localparam int DrainCycles = 100;

	typedef struct packed {
		logic signed [15:0] temp;
		logic [19:0]        pres;
		status_t            st;
	} comp_t;

	typedef enum logic [1:0] {ROW_CFG, ROW_SMP, ROW_SMP_CHK} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		reg_idx_t    idx;
		logic [63:0] wdata;
		logic [15:0] ut;
		logic [18:0] up;
		comp_t       known;
	} row_t;

	logic clk;
	logic arst_n;

	bic_stream_if #(CfgW) cfg_if ();
	bic_stream_if #(SmpW) smp_if ();
	bic_stream_if #(ResW) res_if ();

	barometer_integer_compensation u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_wr  (cfg_if.sink),
		.samples (smp_if.sink),
		.results (res_if.source)
	);

	// calibration shadow
	logic [63:0] cal_a, cal_b;
	logic [31:0] cal_c;
	logic [1:0]  cal_oss;

	comp_t expected_q[$];
	int    send_idle_pct, recv_stall_pct;
	int    mismatches, checked, quiet_cycles, samples_sent;
	int    status_seen[5];

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// sign extension of a 16-bit coefficient
	function automatic logic [31:0] ext16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic logic [31:0] sra(input logic [31:0] v, input int n);
		return $signed(v) >>> n;
	endfunction

	// signed quotient rounded toward zero
	function automatic logic [31:0] div_trunc(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] ma, mb, q;
		ma = a[31] ? -a : a;
		mb = b[31] ? -b : b;
		q = ma / mb;
		return (a[31] != b[31]) ? -q : q;
	endfunction

	// compensated temperature and pressure for one raw pair
	function automatic comp_t compensate(input logic [15:0] raw_t, input logic [18:0] raw_p);
		logic [31:0] ut, up, ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
		logic [31:0] x1, x2, x3, den, b5, b6, sq, b3, b4, b7, p;
		logic signed [31:0] ts, ps;
		comp_t r;
		r = '{temp: '0, pres: '0, st: ST_OK};
		ut = {16'd0, raw_t};
		up = {13'd0, raw_p};
		ac1 = ext16(cal_a[15:0]);
		ac2 = ext16(cal_a[31:16]);
		ac3 = ext16(cal_a[47:32]);
		ac4 = {16'd0, cal_a[63:48]};
		ac5 = {16'd0, cal_b[15:0]};
		ac6 = {16'd0, cal_b[31:16]};
		b1 = ext16(cal_b[47:32]);
		b2 = ext16(cal_b[63:48]);
		mc = ext16(cal_c[15:0]);
		md = ext16(cal_c[31:16]);
		if (ut == 0 || up == 0) begin
			r.st = ST_RAW_ZERO;
			return r;
		end
		x1 = sra((ut - ac6) * ac5, 15);
		den = x1 + md;
		if (den == 0) begin
			r.st = ST_DEN_ZERO;
			return r;
		end
		x2 = div_trunc(mc * 32'd2048, den);
		b5 = x1 + x2;
		ts = sra(b5 + 32'd8, 4);
		if (ts > 32767) ts = 32767;
		if (ts < -32768) ts = -32768;
		r.temp = ts[15:0];
		// pressure path
		b6 = b5 - 32'd4000;
		sq = sra(b6 * b6, 12);
		x1 = sra(b2 * sq, 11);
		x2 = sra(ac2 * b6, 11);
		x3 = x1 + x2;
		b3 = sra(((ac1 * 32'd4 + x3) << cal_oss) + 32'd2, 2);
		x1 = sra(ac3 * b6, 13);
		x2 = sra(b1 * sq, 16);
		x3 = sra(x1 + x2 + 32'd2, 2);
		b4 = (ac4 * (x3 + 32'd32768)) >> 15;
		if (b4 == 0) begin
			r.st = ST_B4_ZERO;
			return r;
		end
		b7 = (up - b3) * (32'd50000 >> cal_oss);
		if (!b7[31]) p = (b7 * 32'd2) / b4;
		else p = (b7 / b4) * 32'd2;
		x1 = sra(p, 8) * sra(p, 8);
		x1 = sra(x1 * 32'd3038, 16);
		x2 = sra(-32'd7357 * p, 16);
		p = p + sra(x1 + x2 + 32'd3791, 4);
		ps = p;
		if (ps <= 0) begin
			r.st = ST_P_NONPOS;
			return r;
		end
		if (ps > 1048575) ps = 1048575;
		r.pres = ps[19:0];
		return r;
	endfunction

	// register write beat
	task automatic write_reg(input reg_idx_t idx, input logic [63:0] v);
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.data <= {8'(idx), v};
		do @(posedge clk); while (!cfg_if.ready);
		case (idx)
			REG_GROUP_A: cal_a = v;
			REG_GROUP_B: cal_b = v;
			REG_GROUP_C: cal_c = v[31:0];
			REG_OSS:     cal_oss = v[1:0];
		endcase
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	task automatic wait_idle();
		while (expected_q.size() != 0) @(posedge clk);
	endtask

	// one sample beat; valid stays high into the next call unless it idles
	task automatic send_sample(input logic [15:0] ut, input logic [18:0] up,
			input bit has_known, input comp_t known);
		comp_t e;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			smp_if.valid <= 1'b0;
			@(negedge clk);
		end
		smp_if.valid <= 1'b1;
		smp_if.data <= {up, ut};
		do @(posedge clk); while (!smp_if.ready);
		e = compensate(ut, up);
		if (has_known && e != known)
			$display("table row disagrees with model: ut=%0d up=%0d", ut, up);
		expected_q.push_back(has_known ? known : e);
		samples_sent++;
	endtask

	task automatic end_burst();
		@(negedge clk);
		smp_if.valid <= 1'b0;
	endtask

	// receiver stalls
	always @(negedge clk)
		res_if.ready <= ($urandom_range(99) >= recv_stall_pct);

	// result checker
	always @(posedge clk) begin
		comp_t got, want;
		if (arst_n && res_if.valid && res_if.ready) begin
			got.temp = res_if.data[15:0];
			got.pres = res_if.data[35:16];
			got.st   = status_t'(res_if.data[38:36]);
			checked++;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat t=%0d p=%0d st=%0d",
						got.temp, got.pres, got.st);
			end else begin
				want = expected_q.pop_front();
				if (got.st <= ST_P_NONPOS) status_seen[got.st]++;
				if (got.temp !== want.temp || got.pres !== want.pres || got.st !== want.st) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp t=%0d p=%0d st=%0d, got t=%0d p=%0d st=%0d",
							want.temp, want.pres, want.st, got.temp, got.pres, got.st);
				end
			end
		end
	end

	// watchdog on beats of any channel
	initial begin
		quiet_cycles = 0;
		forever begin
			@(posedge clk);
			if ((smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready)
					|| (cfg_if.valid && cfg_if.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WatchdogLimit) begin
				$display("watchdog expired, %0d results outstanding", expected_q.size());
				$display("** barometer_integer_compensation: FAILED **");
				$finish;
			end
		end
	end

	// calibration for a random phase
	task automatic pick_calibration(input int phase);
		logic [63:0] a, b;
		logic [31:0] c;
		case (phase % 5)
			0: begin
				// typical datasheet style part with jitter
				a = {16'd32741 + 16'($urandom_range(200)), 16'(-14383), 16'(-72), 16'd408};
				b = {16'd4, 16'd6190, 16'd23153 + 16'($urandom_range(500)), 16'd32757};
				c = {16'd2868, 16'(-8711)};
			end
			1: begin
				a = {$urandom, $urandom};
				b = {$urandom, $urandom};
				c = $urandom;
			end
			2: begin
				a = '1;
				b = '1;
				c = '1;
			end
			3: begin
				a = {16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF};
				b = {16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF};
				c = {16'h8000, 16'h8000};
			end
			default: begin
				a = {16'($urandom_range(40000, 20000)), 16'($urandom), 16'($urandom),
					16'($urandom)};
				b = {16'($urandom_range(9)), 16'($urandom), 16'($urandom_range(30000, 15000)),
					16'($urandom_range(33000, 20000))};
				c = {16'($urandom_range(3000, 1)), 16'($urandom)};
			end
		endcase
		write_reg(REG_GROUP_A, a);
		write_reg(REG_GROUP_B, b);
		write_reg(REG_GROUP_C, {32'd0, c});
		write_reg(REG_OSS, 64'(phase % 4));
	endtask

	row_t plan[$];

	initial begin
		logic [15:0] ut;
		logic [18:0] up;
		int pick;
		comp_t z;
		arst_n = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.data = '0;
		smp_if.valid = 1'b0;
		smp_if.data = '0;
		res_if.ready = 1'b0;
		cal_a = '0;
		cal_b = '0;
		cal_c = '0;
		cal_oss = '0;
		send_idle_pct = 24;
		recv_stall_pct = 56;
		mismatches = 0;
		checked = 0;
		samples_sent = 0;
		z = '{temp: '0, pres: '0, st: ST_OK};
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// reset calibration: zero denominator or zero raw values
		plan.push_back('{ROW_SMP_CHK, REG_GROUP_A, 0, 16'd0, 19'd100, '{0, 0, ST_RAW_ZERO}});
		plan.push_back('{ROW_SMP_CHK, REG_GROUP_A, 0, 16'd100, 19'd0, '{0, 0, ST_RAW_ZERO}});
		plan.push_back('{ROW_SMP_CHK, REG_GROUP_A, 0, 16'hFFFF, 19'h7FFFF, '{0, 0, ST_DEN_ZERO}});
		plan.push_back('{ROW_SMP_CHK, REG_GROUP_A, 0, 16'd1, 19'd1, '{0, 0, ST_DEN_ZERO}});
		// typical calibration
		plan.push_back('{ROW_CFG, REG_GROUP_A, {16'd32741, 16'(-14383), 16'(-72), 16'd408},
			0, 0, z});
		plan.push_back('{ROW_CFG, REG_GROUP_B, {16'd4, 16'd6190, 16'd23153, 16'd32757}, 0, 0, z});
		plan.push_back('{ROW_CFG, REG_GROUP_C, {32'd0, 16'd2868, 16'(-8711)}, 0, 0, z});
		plan.push_back('{ROW_SMP_CHK, REG_GROUP_A, 0, 16'd27898, 19'd23843,
			'{16'sd150, 20'd69964, ST_OK}});
		plan.push_back('{ROW_SMP, REG_GROUP_A, 0, 16'hFFFF, 19'h7FFFF, z});
		plan.push_back('{ROW_SMP, REG_GROUP_A, 0, 16'd1, 19'd1, z});
		plan.push_back('{ROW_SMP, REG_GROUP_A, 0, 16'h8000, 19'h40000, z});
		plan.push_back('{ROW_SMP, REG_GROUP_A, 0, 16'd23153, 19'd30000, z});
		plan.push_back('{ROW_CFG, REG_OSS, 64'd3, 0, 0, z});
		plan.push_back('{ROW_SMP, REG_GROUP_A, 0, 16'd27898, 19'd190744, z});
		plan.push_back('{ROW_SMP, REG_GROUP_A, 0, 16'd27898, 19'h7FFFF, z});
		plan.push_back('{ROW_SMP, REG_GROUP_A, 0, 16'd27898, 19'd1, z});
		// zero ac4 gives a zero b4
		plan.push_back('{ROW_CFG, REG_GROUP_A, {16'd0, 16'(-14383), 16'(-72), 16'd408}, 0, 0, z});
		plan.push_back('{ROW_SMP, REG_GROUP_A, 0, 16'd27898, 19'd23843, z});
		plan.push_back('{ROW_SMP, REG_GROUP_A, 0, 16'd40000, 19'd5, z});

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				end_burst();
				wait_idle();
				write_reg(plan[i].idx, plan[i].wdata);
			end else begin
				send_sample(plan[i].ut, plan[i].up, plan[i].kind == ROW_SMP_CHK, plan[i].known);
			end
		end
		end_burst();

		// random phases with three idling mixes
		for (int ph = 0; ph < 8; ph++) begin
			wait_idle();
			if (ph == 3) begin
				send_idle_pct = 56;
				recv_stall_pct = 24;
			end else if (ph == 6) begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			pick_calibration(ph);
			for (int k = 0; k < 200; k++) begin
				pick = $urandom_range(99);
				if (pick < 70) begin
					ut = 16'($urandom_range(45000, 15000));
					up = 19'($urandom_range(45000, 8000) << cal_oss);
				end else if (pick < 92) begin
					ut = 16'($urandom);
					up = 19'($urandom);
				end else begin
					ut = ($urandom_range(1)) ? 16'd0 : 16'hFFFF;
					up = ($urandom_range(1)) ? 19'd0 : 19'h7FFFF;
				end
				send_sample(ut, up, 1'b0, z);
				// hold off once until the pipeline has emptied
				if (ph == 1 && k == 100) begin
					end_burst();
					wait_idle();
				end
			end
			end_burst();
		end

		wait_idle();
		repeat (DrainCycles) @(posedge clk);
		$display("sent %0d samples over 9 calibrations, checked %0d results", samples_sent,
			checked);
		$display("status mix ok/raw/den/b4/pres: %0d/%0d/%0d/%0d/%0d, mismatches %0d",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4],
			mismatches);
		if (mismatches == 0 && expected_q.size() == 0)
			$display("** barometer_integer_compensation: PASSED **");
		else
			$display("** barometer_integer_compensation: FAILED **");
		$finish;
	end
endmodule
